/* rtl/pvga_pkg.sv */
// Shared types and constants for the pairwise voice grid allocator.
// No dependencies; the row memory, sequencer and top take names from here by scope.
`default_nettype none
package pvga_pkg;

	localparam int LIM_W   = 11;  // voice limit and reported count
	localparam int POS_W   = 10;  // scan positions of a find
	localparam int COORD_W = 6;   // one-based column / row fields
	localparam int IDX_W   = 2;   // config register index

	// widest grid the row memory command can address
	localparam int MAX_SIDE = 64;
	localparam int MAX_AW   = 6;

	localparam logic [1:0] KIND_NOTE  = 2'd0;
	localparam logic [1:0] KIND_FIND  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [IDX_W-1:0] REG_VOICE_LIMIT = 2'd0;
	localparam logic [IDX_W-1:0] REG_CLAIM       = 2'd1;

	typedef enum logic [2:0] {
		ST_RELEASED,
		ST_GRANTED,
		ST_OVERFLOW,
		ST_IGNORED,
		ST_FOUND,
		ST_NONE,
		ST_BAD,
		ST_CLEARED
	} status_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] sender;
		logic [COORD_W-1:0] receiver;
		logic               note_on;
		logic [POS_W-1:0]   low_bound;
		logic [POS_W-1:0]   high_bound;
		logic               transposed;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [LIM_W-1:0]   active_count;
		logic               count_changed;
		logic               room_again;
		logic [COORD_W-1:0] col_out;
		logic [COORD_W-1:0] row_out;
		logic               on_out;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [LIM_W-1:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [LIM_W-1:0] voice_limit;
		logic             claim_on_find;
	} cfg_regs_t;

	// sequencer -> row memory
	typedef struct packed {
		logic                rd_en;
		logic [MAX_AW-1:0]   rd_row;
		logic                wr_en;
		logic [MAX_AW-1:0]   wr_row;
		logic [MAX_SIDE-1:0] wr_data;
		logic                clr;
	} mem_cmd_t;

endpackage
`default_nettype wire

/* rtl/pvga_chan_if.sv */
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance; used for request, response and config.
`default_nettype none
interface pvga_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/pvga_row_mem.sv */
// Occupancy map: one memory row per grid row, one bit per column.
// Row valid flops make a clear instant. Depends on pvga_pkg.
`default_nettype none
module pvga_row_mem #(
	parameter int GRID_SIDE = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pvga_pkg::mem_cmd_t   cmd,
	output logic      [GRID_SIDE-1:0] rd_data
);

	localparam int AW = $clog2(GRID_SIDE);

	logic [GRID_SIDE-1:0] mem [GRID_SIDE];
	logic [GRID_SIDE-1:0] row_vld_q;
	logic [GRID_SIDE-1:0] rd_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_row[AW-1:0]] <= cmd.wr_data[GRID_SIDE-1:0];
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_row[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.clr) begin
				row_vld_q <= '0;
			end else if (cmd.wr_en) begin
				row_vld_q[cmd.wr_row[AW-1:0]] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= row_vld_q[cmd.rd_row[AW-1:0]];
			end
		end
	end

	// a row never written since the last clear reads as all free
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

/* rtl/pvga_seq.sv */
// Sequencer: decodes items, read-modify-writes map rows, runs the find scan,
// keeps the voice count and the result register. Depends on pvga_pkg, pvga_chan_if.
`default_nettype none
module pvga_seq #(
	parameter int GRID_SIDE = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pvga_chan_if.sink                  req,
	pvga_chan_if.source                rsp,
	input  wire pvga_pkg::cfg_regs_t   cfg_regs,
	output pvga_pkg::mem_cmd_t         mem_cmd,
	input  wire logic [GRID_SIDE-1:0]  mem_rd_data
);

	localparam int AW    = $clog2(GRID_SIDE);
	localparam int CELLS = GRID_SIDE * GRID_SIDE;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int LIM_W = pvga_pkg::LIM_W;
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int CW    = pvga_pkg::COORD_W;
	localparam int PW    = pvga_pkg::POS_W;
	localparam int MAW   = pvga_pkg::MAX_AW;
	localparam int MSD   = pvga_pkg::MAX_SIDE;

	typedef enum logic [1:0] {S_IDLE, S_NOTE, S_SCAN, S_HOLD} state_t;

	state_t             state_q, state_nx;
	logic [CNT_W-1:0]   count_q, count_nx;
	pvga_pkg::req_t     item_q;
	pvga_pkg::rsp_t     res_q, res_nx, out_q;
	logic               out_vld_q;
	logic               res_ld;

	// scan counters and the stage that waits on the row read
	logic [PW-1:0]      p_q;
	logic [AW-1:0]      min_q, maj_q;
	logic               s1_vld_q, s1_last_q;
	logic [PW-1:0]      p_s1;
	logic [AW-1:0]      row_s1, col_s1;
	logic               scan_iss;

	logic               accept, out_free;
	logic               in_rng, bad_bounds;
	logic [AW-1:0]      in_row, n_row, n_col, w_col;
	logic               w_bit, cur_bit, hit;
	logic [GRID_SIDE-1:0] row_mod;
	logic [CMP_W-1:0]   cnt_ext, lim_ext;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign in_rng = (req.data.sender != '0) && (int'(req.data.sender) <= GRID_SIDE) &&
		(req.data.receiver != '0) && (int'(req.data.receiver) <= GRID_SIDE);
	assign bad_bounds = (req.data.low_bound > req.data.high_bound) ||
		(int'(req.data.high_bound) >= CELLS);
	assign in_row = AW'(req.data.receiver - CW'(1));
	assign n_row  = AW'(item_q.receiver - CW'(1));
	assign n_col  = AW'(item_q.sender - CW'(1));

	assign cnt_ext = CMP_W'(count_q);
	assign lim_ext = CMP_W'(cfg_regs.voice_limit);

	assign cur_bit = mem_rd_data[n_col];
	assign hit     = s1_vld_q && (p_s1 >= item_q.low_bound) && !mem_rd_data[col_s1];

	// row write-back: note events set or clear their bit, a claimed find sets it
	assign w_col = (state_q == S_SCAN) ? col_s1 : n_col;
	assign w_bit = (state_q == S_SCAN) ? 1'b1 : item_q.note_on;
	always_comb begin
		row_mod        = mem_rd_data;
		row_mod[w_col] = w_bit;
	end

	always_comb begin
		state_nx = state_q;
		count_nx = count_q;
		res_nx   = '0;
		res_ld   = 1'b0;
		scan_iss = 1'b0;
		mem_cmd  = '0;
		mem_cmd.wr_data = MSD'(row_mod);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.kind)
						pvga_pkg::KIND_NOTE: begin
							if (in_rng) begin
								mem_cmd.rd_en  = 1'b1;
								mem_cmd.rd_row = MAW'(in_row);
								state_nx       = S_NOTE;
							end else begin
								res_nx.status  = pvga_pkg::ST_IGNORED;
								res_nx.col_out = req.data.sender;
								res_nx.row_out = req.data.receiver;
								res_ld         = 1'b1;
								state_nx       = S_HOLD;
							end
						end
						pvga_pkg::KIND_FIND: begin
							if (bad_bounds) begin
								res_nx.status = pvga_pkg::ST_BAD;
								res_ld        = 1'b1;
								state_nx      = S_HOLD;
							end else begin
								state_nx = S_SCAN;
							end
						end
						pvga_pkg::KIND_CLEAR: begin
							mem_cmd.clr          = 1'b1;
							count_nx             = '0;
							res_nx.status        = pvga_pkg::ST_CLEARED;
							res_nx.count_changed = 1'b1;
							res_ld               = 1'b1;
							state_nx             = S_HOLD;
						end
						default: begin
							res_nx.status = pvga_pkg::ST_IGNORED;
							res_ld        = 1'b1;
							state_nx      = S_HOLD;
						end
					endcase
				end
			end
			S_NOTE: begin
				res_nx.col_out = item_q.sender;
				res_nx.row_out = item_q.receiver;
				mem_cmd.wr_row = MAW'(n_row);
				if (!item_q.note_on) begin
					if (cur_bit) begin
						mem_cmd.wr_en        = 1'b1;
						count_nx             = count_q - CNT_W'(1);
						res_nx.status        = pvga_pkg::ST_RELEASED;
						res_nx.count_changed = 1'b1;
						res_nx.room_again    = (cnt_ext - CMP_W'(1)) < lim_ext;
					end else begin
						// releasing a free cell reports as overflow
						res_nx.status = pvga_pkg::ST_OVERFLOW;
					end
				end else if (cur_bit) begin
					res_nx.status = pvga_pkg::ST_IGNORED;
				end else if (cnt_ext < lim_ext) begin
					mem_cmd.wr_en        = 1'b1;
					count_nx             = count_q + CNT_W'(1);
					res_nx.status        = pvga_pkg::ST_GRANTED;
					res_nx.count_changed = 1'b1;
				end else begin
					res_nx.status = pvga_pkg::ST_OVERFLOW;
					res_nx.on_out = 1'b1;
				end
				res_ld   = 1'b1;
				state_nx = S_HOLD;
			end
			S_SCAN: begin
				if (hit) begin
					res_nx.status        = pvga_pkg::ST_FOUND;
					res_nx.col_out       = CW'(col_s1) + CW'(1);
					res_nx.row_out       = CW'(row_s1) + CW'(1);
					res_nx.count_changed = cfg_regs.claim_on_find;
					res_nx.on_out        = cfg_regs.claim_on_find;
					if (cfg_regs.claim_on_find) begin
						mem_cmd.wr_en  = 1'b1;
						mem_cmd.wr_row = MAW'(row_s1);
						count_nx       = count_q + CNT_W'(1);
					end
					res_ld   = 1'b1;
					state_nx = S_HOLD;
				end else if (s1_vld_q && s1_last_q) begin
					res_nx.status = pvga_pkg::ST_NONE;
					res_ld        = 1'b1;
					state_nx      = S_HOLD;
				end else begin
					scan_iss       = 1'b1;
					mem_cmd.rd_en  = 1'b1;
					mem_cmd.rd_row = MAW'(item_q.transposed ? min_q : maj_q);
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		res_nx.active_count = LIM_W'(count_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			res_q     <= '0;
			out_q     <= '0;
			out_vld_q <= 1'b0;
			s1_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			count_q <= count_nx;
			if (res_ld) begin
				res_q <= res_nx;
			end
			if (accept) begin
				s1_vld_q <= 1'b0;
			end else if (scan_iss) begin
				s1_vld_q <= 1'b1;
			end
			if (state_q == S_HOLD && out_free) begin
				out_q     <= res_q;
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// position p walks minor index p % side and major index p / side;
	// positions below low_bound are read but never tested
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
			p_q    <= '0;
			min_q  <= '0;
			maj_q  <= '0;
		end else if (scan_iss) begin
			p_s1      <= p_q;
			s1_last_q <= (p_q == item_q.high_bound);
			row_s1    <= item_q.transposed ? min_q : maj_q;
			col_s1    <= item_q.transposed ? maj_q : min_q;
			p_q       <= p_q + PW'(1);
			if (min_q == AW'(GRID_SIDE - 1)) begin
				min_q <= '0;
				maj_q <= maj_q + AW'(1);
			end else begin
				min_q <= min_q + AW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/pairwise_voice_grid_allocator_top.sv */
// Top level of the pairwise voice grid allocator: config registers, row memory
// and sequencer. Depends on pvga_pkg, pvga_chan_if, pvga_row_mem, pvga_seq.
`default_nettype none
// The block holds a GRID_SIDE x GRID_SIDE occupancy map in a row-wide memory
// (one row per receiver, one bit per sender) with registered reads, plus a
// voice count that note-on grants keep within voice_limit (a claimed find does
// not check it). One item is in work at a time. A note event reads its row,
// then writes it back and updates the count; its result goes through the result
// register and the output register, and the next item can be taken while that
// result beat is shown. A clear, a bad-bounds find or an out-of-range note
// skips the memory read and goes straight to the result register. A find walks
// scan positions 0 to high_bound, one per cycle through the single memory read
// port, and stops at the first free cell at or above low_bound. Clearing is
// instant through per-row valid flops, so there is no clearing pass after reset.
// The result sits in an output register, so the next item is taken while a
// finished result still waits for ready.
// Configuration writes are always accepted; write them only while idle.
module pairwise_voice_grid_allocator_top #(
	parameter int GRID_SIDE = 32
) (
	input wire logic    clk,
	input wire logic    arst_n,
	pvga_chan_if.sink   cfg,
	pvga_chan_if.sink   req,
	pvga_chan_if.source rsp
);

	pvga_pkg::cfg_regs_t  cfg_regs_q;
	pvga_pkg::mem_cmd_t   mem_cmd;
	logic [GRID_SIDE-1:0] mem_rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_regs_q.voice_limit   <= pvga_pkg::LIM_W'(1);
			cfg_regs_q.claim_on_find <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				pvga_pkg::REG_VOICE_LIMIT: cfg_regs_q.voice_limit <= cfg.data.wdata;
				pvga_pkg::REG_CLAIM:       cfg_regs_q.claim_on_find <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	pvga_row_mem #(.GRID_SIDE(GRID_SIDE)) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mem_cmd),
		.rd_data (mem_rd_data)
	);

	pvga_seq #(.GRID_SIDE(GRID_SIDE)) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_regs    (cfg_regs_q),
		.mem_cmd     (mem_cmd),
		.mem_rd_data (mem_rd_data)
	);

	// one item at a time: the beat after an accept is never accepted
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous item in work");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == pvga_pkg::ST_CLEARED |->
			rsp.data.active_count == '0 && rsp.data.count_changed)
		else $error("clear result reports occupied cells");

	a_grant_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == pvga_pkg::ST_GRANTED |->
			rsp.data.active_count <= cfg_regs_q.voice_limit)
		else $error("grant pushed count above voice limit");

	a_miss_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.status == pvga_pkg::ST_NONE ||
			rsp.data.status == pvga_pkg::ST_BAD) |->
			rsp.data.col_out == '0 && rsp.data.row_out == '0 && !rsp.data.count_changed)
		else $error("failed find reports a cell or a count change");

endmodule
`default_nettype wire
